/* hw/rtl/fir_pkg.sv */
// Shared types, codes and sizes for the FIR filter.
package fir_pkg;

	localparam int TAPS_DEF = 32;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int INDEX_W  = 5;
	localparam int FUNC_W   = 2;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int FRAC_W   = 15;

	// Request kinds carried on s_tuser.
	localparam logic [FUNC_W-1:0] FN_FILTER = 2'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// Broadcast controls to every tap cell.
	typedef struct packed {
		logic shift;
		logic rotate;
		logic clear;
		logic wr;
	} cell_ctl_t;

endpackage

/* hw/rtl/fir_filter_top.sv */
// Top level of the direct-form FIR filter: tap ring, shared MAC and control.
//
// Usage:
//   Input stream (s_*): one request per handshake. s_tuser holds the request kind:
//     filter sample, write coefficient, or clear sample history (code 3 is ignored).
//     s_tdata holds sample, tap_index and tap_value packed from bit 0 up.
//   Output stream (m_*): one result per filter request. m_tdata is the
//     rounded, saturated 16-bit output; m_tuser flags that the sum was clipped.
//   Coefficient writes, clears and ignored codes give no result.
// Sequencing:
//   A filter request shifts the sample into the tap ring on accept, then the
//   ring rotates once per cycle in the run state, feeding one tap pair per cycle
//   into the single multiplier until every tap is fed. A drain state and a
//   round/saturate state follow, and the next request is taken only once the
//   result is loaded into the output register, so requests never overlap.
//   The shared multiply-accumulate sets this limit.
// Reset: history and coefficients clear to zero, output holds no result.
// Stall: a result sits in the output register until m_tready; the next filter
//   request is still accepted, and its result waits for the register to free.
module fir_filter_top import fir_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // sample[15:0], tap_index[20:16], tap_value[38:21], zero
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // filtered[15:0]
	output logic [0:0]  m_tuser   // saturated[0]
);

	localparam int ACC_W = PROD_W + $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS);
	localparam int Y_W   = ACC_W + 1 - FRAC_W;
	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
	localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-32768);

	// unpacked request fields
	logic        [FUNC_W-1:0]   func;
	logic signed [SAMPLE_W-1:0] sample;
	logic        [INDEX_W-1:0]  tap_index;
	logic signed [COEF_W-1:0]   tap_value;

	assign func      = s_tuser;
	assign sample    = s_tdata[15:0];
	assign tap_index = s_tdata[20:16];
	assign tap_value = s_tdata[38:21];

	state_t     state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic       accept;
	logic       last_tap;
	logic       out_load;
	cell_ctl_t  ctl;
	logic       mac_start;
	logic       mac_en;

	logic signed [SAMPLE_W-1:0] hist_w [TAPS];
	logic signed [COEF_W-1:0]   coef_w [TAPS];
	logic signed [ACC_W-1:0]    acc;

	logic signed [ACC_W:0]      biased;
	logic signed [Y_W-1:0]      y;
	logic signed [SAMPLE_W-1:0] filtered_nx;
	logic                       sat_nx;

	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic                       saturated_q;

	assign accept   = s_tvalid && s_tready;
	assign last_tap = cnt_q == CNT_W'(TAPS - 1);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FN_FILTER) state_nx = ST_RUN;
			end
			ST_RUN: begin
				if (last_tap) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_FIN;
			ST_FIN: begin
				if (out_load) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready   = state_q == ST_IDLE;
		ctl.shift  = accept && func == FN_FILTER;
		ctl.wr     = accept && func == FN_WRITE;
		ctl.clear  = accept && func == FN_CLEAR;
		ctl.rotate = state_q == ST_RUN;
		mac_start  = ctl.shift;
		mac_en     = state_q == ST_RUN;
		out_load   = state_q == ST_FIN && (!out_vld_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Tap ring: shift moves samples toward higher taps, rotate moves every
	// pair one cell down so cell 0 presents tap k on the k-th run cycle.
	// After TAPS rotations the ring is back in place.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		localparam int NXT = (k + 1) % TAPS;
		localparam int PRV = (k + TAPS - 1) % TAPS;
		logic signed [SAMPLE_W-1:0] shift_in;

		assign shift_in = (k == 0) ? sample : hist_w[PRV];

		fir_cell #(
			.IDX(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.tap_index  (tap_index),
			.tap_value  (tap_value),
			.shift_in   (shift_in),
			.rot_hist_in(hist_w[NXT]),
			.rot_coef_in(coef_w[NXT]),
			.hist       (hist_w[k]),
			.coef       (coef_w[k])
		);
	end

	fir_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mac_start),
		.en    (mac_en),
		.hist  (hist_w[0]),
		.coef  (coef_w[0]),
		.acc   (acc)
	);

	// round half up, scale by 2^-15, clamp to 16 bits
	always_comb begin
		biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_W - 1));
		y      = biased[ACC_W:FRAC_W];
		if (y > Y_MAX) begin
			filtered_nx = 16'sh7fff;
			sat_nx      = 1'b1;
		end else if (y < Y_MIN) begin
			filtered_nx = 16'sh8000;
			sat_nx      = 1'b1;
		end else begin
			filtered_nx = y[SAMPLE_W-1:0];
			sat_nx      = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q  <= filtered_nx;
			saturated_q <= sat_nx;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = filtered_q;
	assign m_tuser[0] = saturated_q;

endmodule

/* hw/rtl/fir_cell.sv */
// One tap cell: holds one history sample and one coefficient.
module fir_cell import fir_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctl_t                  ctl,
	input  logic        [INDEX_W-1:0]  tap_index,
	input  logic signed [COEF_W-1:0]   tap_value,
	input  logic signed [SAMPLE_W-1:0] shift_in,
	input  logic signed [SAMPLE_W-1:0] rot_hist_in,
	input  logic signed [COEF_W-1:0]   rot_coef_in,
	output logic signed [SAMPLE_W-1:0] hist,
	output logic signed [COEF_W-1:0]   coef
);

	// only the first 2^INDEX_W cells are addressable
	localparam bit WR_OK = IDX < (1 << INDEX_W);

	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [COEF_W-1:0]   coef_q;
	logic                       wr_hit;

	assign wr_hit = ctl.wr && WR_OK && (tap_index == INDEX_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.clear) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= shift_in;
		end else if (ctl.rotate) begin
			hist_q <= rot_hist_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_hit) begin
			coef_q <= tap_value;
		end else if (ctl.rotate) begin
			coef_q <= rot_coef_in;
		end
	end

	assign hist = hist_q;
	assign coef = coef_q;

endmodule

/* hw/rtl/fir_mac.sv */
// Shared multiply-accumulate fed from the head of the tap ring.
module fir_mac import fir_pkg::*; #(
	parameter int ACC_W = 39
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] hist,
	input  logic signed [COEF_W-1:0]   coef,
	output logic signed [ACC_W-1:0]    acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= en;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= hist * coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (start) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	assign acc = acc_q;

endmodule

/* tb/sv/tb.sv */
// Self-checking stream testbench for fir_filter_top: FIR filter, coefficient load, clear and unused codes.
module tb;
	import fir_pkg::*;

	localparam int TAPS           = TAPS_DEF;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 1530;
	localparam int HOLD_EVERY     = 400;   // random requests between full drains
	localparam int CALM_ITEMS     = 150;   // tail of the run without idling
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side

	typedef struct {
		logic [FUNC_W-1:0]          func;
		logic signed [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]         tap_index;
		logic signed [COEF_W-1:0]   tap_value;
		bit                         hold;  // wait until every pending result is back
	} fir_req_t;

	typedef struct {
		logic [SAMPLE_W-1:0] filtered;
		logic                saturated;
	} fir_out_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [39:0]        s_tdata  = '0;
	logic [FUNC_W-1:0]  s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;
	logic [0:0]         m_tuser;

	fir_filter_top #(.TAPS(TAPS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state
	logic signed [SAMPLE_W-1:0] sample_line [TAPS];
	logic signed [COEF_W-1:0]   coef_bank   [TAPS];
	fir_out_t                   expected_out [$];
	fir_req_t                   pending_req  [$];

	int  n_predicted  = 0;
	int  results_done = 0;  // updated with NBA so the sender sees a stable count
	int  n_filters = 0, n_writes = 0, n_clears = 0, n_ignored = 0, n_clipped = 0;
	int  errors = 0;
	int  gap_left = 0, stall_left = 0, idle_cycles = 0;
	bit  calm = 1'b0;
	fir_req_t cur_req;

	function automatic void predict_request(input fir_req_t r);
		longint   acc;
		longint   y;
		fir_out_t res;
		case (r.func)
			FN_WRITE: begin
				if (r.tap_index < TAPS)
					coef_bank[r.tap_index] = r.tap_value;
				n_writes++;
			end
			FN_CLEAR: begin
				foreach (sample_line[k]) sample_line[k] = '0;
				n_clears++;
			end
			FN_FILTER: begin
				for (int k = TAPS - 1; k > 0; k--)
					sample_line[k] = sample_line[k - 1];
				sample_line[0] = r.sample;
				acc = 0;
				for (int k = 0; k < TAPS; k++)
					acc += longint'(coef_bank[k]) * longint'(sample_line[k]);
				// round half toward +inf, then drop the 15 fraction bits
				y = (acc + 64'sd16384) >>> FRAC_W;
				res.saturated = 1'b0;
				if (y > 32767) begin
					y = 32767;
					res.saturated = 1'b1;
				end else if (y < -32768) begin
					y = -32768;
					res.saturated = 1'b1;
				end
				res.filtered = y[15:0];
				if (res.saturated)
					n_clipped++;
				expected_out.push_back(res);
				n_predicted++;
				n_filters++;
			end
			default: n_ignored++;
		endcase
	endfunction

	// Unused fields carry random bits so every field bit of tdata toggles; bit 39 stays zero.
	function automatic fir_req_t rand_req(input logic [FUNC_W-1:0] f);
		fir_req_t r;
		r.func      = f;
		r.sample    = SAMPLE_W'($urandom);
		r.tap_index = INDEX_W'($urandom);
		r.tap_value = COEF_W'($urandom);
		r.hold      = 1'b0;
		return r;
	endfunction

	function automatic void push_filter(input logic signed [SAMPLE_W-1:0] smp);
		fir_req_t r;
		r = rand_req(FN_FILTER);
		r.sample = smp;
		pending_req.push_back(r);
	endfunction

	function automatic void push_write(input logic [INDEX_W-1:0] idx,
	                                   input logic signed [COEF_W-1:0] val);
		fir_req_t r;
		r = rand_req(FN_WRITE);
		r.tap_index = idx;
		r.tap_value = val;
		pending_req.push_back(r);
	endfunction

	// Sender: one request in flight on s_*, refilled from pending_req.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			calm     <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_request(cur_req);
			calm <= (pending_req.size() < CALM_ITEMS);
			if (!s_tvalid || s_tready) begin
				if (pending_req.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_req[0].hold && n_predicted != results_done) begin
					s_tvalid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(1, 12) - 1;
					s_tvalid <= 1'b0;
				end else begin
					cur_req = pending_req.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, cur_req.tap_value, cur_req.tap_index, cur_req.sample};
					s_tuser  <= cur_req.func;
				end
			end
		end
	end

	// Receiver: random backpressure bursts, checks each result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual filtered=%0d sat=%0b",
					         $time, $signed(m_tdata), m_tuser[0]);
				end else begin
					fir_out_t e;
					e = expected_out.pop_front();
					if (m_tdata !== e.filtered) begin
						errors++;
						$display("%0t: filtered mismatch: expected %0d, actual %0d",
						         $time, $signed(e.filtered), $signed(m_tdata));
					end
					if (m_tuser[0] !== e.saturated) begin
						errors++;
						$display("%0t: saturated mismatch: expected %0b, actual %0b",
						         $time, e.saturated, m_tuser[0]);
					end
					results_done <= results_done + 1;
				end
			end
			if (calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int       n;
		int       pick;
		int       mode;
		logic signed [SAMPLE_W-1:0] smp;
		logic signed [COEF_W-1:0]   cv;

		foreach (sample_line[k]) sample_line[k] = '0;
		foreach (coef_bank[k]) coef_bank[k] = '0;

		// Directed: zero taps, unity tap, extreme taps and samples, rounding halves,
		// unused code, clear, last tap index.
		push_filter(16'sh7FFF);
		push_write(5'd0, 18'sd32768);
		push_filter(16'sh7FFF);
		push_filter(-16'sh8000);
		push_filter(16'sd0);
		push_write(5'd31, -18'sd131072);
		push_write(5'd0, 18'sd131071);
		push_filter(16'sh7FFF);
		push_filter(-16'sh8000);
		push_write(5'd0, -18'sd131072);
		push_filter(-16'sh8000);
		push_filter(16'sh7FFF);
		push_write(5'd0, 18'sd1);
		push_filter(16'sd16384);
		push_filter(-16'sd16384);
		pending_req.push_back(rand_req(FN_UNUSED));
		pending_req.push_back(rand_req(FN_CLEAR));
		push_filter(-16'sd1);
		push_write(5'd31, 18'sd32767);
		push_write(5'd15, -18'sd4096);
		push_filter(16'sd12345);

		// Random part: mostly filter runs over a changing tap set, with occasional
		// clears and unused codes.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			mode = $urandom_range(0, 9);
			if (pick < 76) begin
				if (mode < 6)
					smp = SAMPLE_W'($urandom);
				else if (mode < 8)
					smp = SAMPLE_W'(int'($urandom_range(0, 2047)) - 1024);
				else
					smp = (mode == 8) ? 16'sh7FFF : -16'sh8000;
				push_filter(smp);
			end else if (pick < 91) begin
				if (mode < 2)
					cv = COEF_W'($urandom);
				else if (mode < 8)
					cv = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
				else if (mode == 8)
					cv = '0;
				else
					cv = $urandom_range(0, 1) ? 18'sd131071 : -18'sd131072;
				push_write(INDEX_W'($urandom), cv);
			end else if (pick < 96) begin
				pending_req.push_back(rand_req(FN_CLEAR));
			end else begin
				pending_req.push_back(rand_req(FN_UNUSED));
			end
			n++;
			if (n % HOLD_EVERY == 1)
				pending_req[pending_req.size() - 1].hold = 1'b1;
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_req.size() != 0 || s_tvalid)
			@(posedge clk);
		while (n_predicted != results_done)
			@(posedge clk);
		repeat (TAPS + 8) @(posedge clk);

		if (expected_out.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_out.size());
		end

		$display("Run covered %0d filter, %0d coefficient-write, %0d clear and %0d unused requests;",
		         n_filters, n_writes, n_clears, n_ignored);
		$display("%0d of %0d results were clipped, %0d mismatches.",
		         n_clipped, n_predicted, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
